[src/fct_pkg.sv]
// ----------------------------------------------------------------------------
// fct_pkg: fragment coverage tracker shared definitions
// Sizes, status codes, and the command/status bundles between controller
// and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package fct_pkg;

  localparam int MAX_CHUNKS = 16;
  localparam int LEN_BITS   = 32;
  localparam int IDX_W      = $clog2(MAX_CHUNKS);
  localparam int CNT_W      = $clog2(MAX_CHUNKS + 1);
  localparam int END_W      = LEN_BITS + 1;
  localparam int HELD_W     = 5;

  typedef logic [LEN_BITS-1:0] len_t;
  typedef logic [END_W-1:0]    end_t;
  typedef logic [CNT_W-1:0]    cnt_t;
  typedef logic [IDX_W-1:0]    idx_t;

  localparam cnt_t MAX_CNT = cnt_t'(MAX_CHUNKS);
  localparam cnt_t CNT_ONE = cnt_t'(1);

  localparam logic [1:0] ST_STORED = 2'd0;
  localparam logic [1:0] ST_DUP    = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  typedef struct packed {
    logic load;
    logic scan_rd;
    logic decide;
    logic shift_rd;
    logic ins;
    logic walk_init;
    logic walk_rd;
    logic out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic more_rd;
    logic more_shift;
    logic ins_go;
  } ctl_sts_t;

  typedef struct packed {
    logic [1:0]        status;
    logic              first_seen_now;
    logic              last_seen_now;
    logic              complete;
    logic              all_verified;
    logic [HELD_W-1:0] chunks_held;
  } fct_res_t;

endpackage

`default_nettype wire

[src/fct_ifs.sv]
// ----------------------------------------------------------------------------
// fct_ifs: fragment coverage tracker channels
// Fragment input, result output, and total-length configuration channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface fct_in_if;
  logic           valid;
  logic           ready;
  fct_pkg::len_t  frag_offset;
  fct_pkg::len_t  frag_length;
  logic           verified;

  modport source (output valid, output frag_offset, output frag_length, output verified,
                  input ready);
  modport sink (input valid, input frag_offset, input frag_length, input verified,
                output ready);
endinterface

interface fct_out_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 status;
  logic                       first_seen_now;
  logic                       last_seen_now;
  logic                       complete;
  logic                       all_verified;
  logic [fct_pkg::HELD_W-1:0] chunks_held;

  modport source (output valid, output status, output first_seen_now,
                  output last_seen_now, output complete, output all_verified,
                  output chunks_held, input ready);
  modport sink (input valid, input status, input first_seen_now,
                input last_seen_now, input complete, input all_verified,
                input chunks_held, output ready);
endinterface

interface fct_cfg_if;
  logic          valid;
  logic          ready;
  fct_pkg::len_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[src/fct_ctrl.sv]
// ----------------------------------------------------------------------------
// fct_ctrl: fragment coverage tracker controller
// Sequences the table scan, insert shift, coverage walk and result handoff.
// ----------------------------------------------------------------------------
`default_nettype none

module fct_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire fct_pkg::ctl_sts_t sts,
  output fct_pkg::ctl_cmd_t      cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_SHIFT  = 3'd3;
  localparam logic [2:0] S_INS    = 3'd4;
  localparam logic [2:0] S_WALK   = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.more_rd) begin
          cmd.scan_rd = 1'b1;
        end else begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        if (sts.ins_go) begin
          state_nxt = S_SHIFT;
        end else begin
          cmd.walk_init = 1'b1;
          state_nxt     = S_WALK;
        end
      end
      S_SHIFT: begin
        if (sts.more_shift) begin
          cmd.shift_rd = 1'b1;
        end else begin
          state_nxt = S_INS;
        end
      end
      S_INS: begin
        cmd.ins       = 1'b1;
        cmd.walk_init = 1'b1;
        state_nxt     = S_WALK;
      end
      S_WALK: begin
        if (sts.more_rd) begin
          cmd.walk_rd = 1'b1;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

[src/fct_datapath.sv]
// ----------------------------------------------------------------------------
// fct_datapath: fragment coverage tracker datapath
// Chunk table memory, scan accumulators, shift pipeline, coverage walk and
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module fct_datapath (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire fct_pkg::ctl_cmd_t cmd,
  output fct_pkg::ctl_sts_t      sts,
  input  wire fct_pkg::len_t     in_offset,
  input  wire fct_pkg::len_t     in_length,
  input  wire logic              in_verified,
  input  wire logic              cfg_we,
  input  wire fct_pkg::len_t     cfg_data,
  output fct_pkg::fct_res_t      res
);

  fct_pkg::len_t mem_start [fct_pkg::MAX_CHUNKS];
  fct_pkg::len_t mem_size  [fct_pkg::MAX_CHUNKS];

  fct_pkg::len_t     total_r;
  fct_pkg::len_t     off_r;
  fct_pkg::len_t     len_r;
  fct_pkg::end_t     fe_r;
  fct_pkg::cnt_t     cnt_r;
  fct_pkg::cnt_t     idx_r;
  fct_pkg::cnt_t     pos_r;
  logic              cov_r;
  logic              pres_r;
  logic              scan_vld_r;
  logic              shift_vld_r;
  logic              walk_vld_r;
  fct_pkg::idx_t     wa_r;
  fct_pkg::len_t     rd_start_r;
  fct_pkg::len_t     rd_size_r;
  fct_pkg::end_t     walk_r;
  logic              gap_r;
  logic              first_done_r;
  logic              last_done_r;
  logic              ver_r;
  logic [1:0]        status_r;
  logic              first_now_r;
  logic              last_now_r;
  fct_pkg::fct_res_t res_r;

  fct_pkg::cnt_t idx_m1;
  fct_pkg::idx_t rd_addr;
  fct_pkg::end_t ce;
  logic          covers;
  logic          ahead;
  logic          same;
  logic          full;
  logic [1:0]    dec_status;
  logic          stored;
  logic          first_hit;
  logic          last_hit;

  assign idx_m1  = idx_r - fct_pkg::CNT_ONE;
  assign rd_addr = cmd.shift_rd ? idx_m1[fct_pkg::IDX_W-1:0] : idx_r[fct_pkg::IDX_W-1:0];

  assign ce     = {1'b0, rd_start_r} + {1'b0, rd_size_r};
  assign covers = (rd_start_r <= off_r) && ({1'b0, off_r} < ce) && (fe_r <= ce);
  assign ahead  = (rd_start_r < off_r) || ((rd_start_r == off_r) && (rd_size_r < len_r));
  assign same   = (rd_start_r == off_r) && (rd_size_r == len_r);

  assign full = (cnt_r >= fct_pkg::MAX_CNT);

  always_comb begin
    if (cov_r) begin
      dec_status = fct_pkg::ST_DUP;
    end else if (pres_r) begin
      dec_status = fct_pkg::ST_STORED;
    end else if (full) begin
      dec_status = fct_pkg::ST_FULL;
    end else begin
      dec_status = fct_pkg::ST_STORED;
    end
  end

  assign stored    = (dec_status == fct_pkg::ST_STORED);
  assign first_hit = stored && !first_done_r && (off_r == '0);
  assign last_hit  = stored && !last_done_r && (fe_r == {1'b0, total_r});

  assign sts.more_rd    = (idx_r < cnt_r);
  assign sts.more_shift = (idx_r > pos_r);
  assign sts.ins_go     = !cov_r && !pres_r && !full;

  assign res = res_r;

  always_ff @(posedge clk) begin
    if (shift_vld_r) begin
      mem_start[wa_r] <= rd_start_r;
      mem_size[wa_r]  <= rd_size_r;
    end else if (cmd.ins) begin
      mem_start[pos_r[fct_pkg::IDX_W-1:0]] <= off_r;
      mem_size[pos_r[fct_pkg::IDX_W-1:0]]  <= len_r;
    end
    rd_start_r <= mem_start[rd_addr];
    rd_size_r  <= mem_size[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      off_r <= in_offset;
      len_r <= in_length;
      fe_r  <= {1'b0, in_offset} + {1'b0, in_length};
    end
    wa_r <= idx_r[fct_pkg::IDX_W-1:0];
    if (cmd.walk_init) begin
      walk_r <= '0;
    end else if (walk_vld_r && (ce > walk_r)) begin
      walk_r <= ce;
    end
    if (cmd.decide) begin
      status_r    <= dec_status;
      first_now_r <= first_hit;
      last_now_r  <= last_hit;
    end
    if (cmd.out_load) begin
      res_r.status         <= status_r;
      res_r.first_seen_now <= first_now_r;
      res_r.last_seen_now  <= last_now_r;
      res_r.complete       <= !gap_r && (walk_r >= {1'b0, total_r});
      res_r.all_verified   <= ver_r;
      res_r.chunks_held    <= fct_pkg::HELD_W'(cnt_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r      <= '0;
      cnt_r        <= '0;
      idx_r        <= '0;
      pos_r        <= '0;
      cov_r        <= 1'b0;
      pres_r       <= 1'b0;
      scan_vld_r   <= 1'b0;
      shift_vld_r  <= 1'b0;
      walk_vld_r   <= 1'b0;
      gap_r        <= 1'b0;
      first_done_r <= 1'b0;
      last_done_r  <= 1'b0;
      ver_r        <= 1'b1;
    end else begin
      scan_vld_r  <= cmd.scan_rd;
      shift_vld_r <= cmd.shift_rd;
      walk_vld_r  <= cmd.walk_rd;

      if (cfg_we) begin
        total_r <= cfg_data;
      end

      if (cmd.load || cmd.walk_init) begin
        idx_r <= '0;
      end else if (cmd.decide && sts.ins_go) begin
        idx_r <= cnt_r;
      end else if (cmd.scan_rd || cmd.walk_rd) begin
        idx_r <= idx_r + fct_pkg::CNT_ONE;
      end else if (cmd.shift_rd) begin
        idx_r <= idx_m1;
      end

      if (cmd.load) begin
        cov_r  <= 1'b0;
        pres_r <= 1'b0;
        pos_r  <= '0;
        ver_r  <= ver_r & in_verified;
      end else if (scan_vld_r) begin
        cov_r  <= cov_r | covers;
        pres_r <= pres_r | same;
        pos_r  <= pos_r + fct_pkg::cnt_t'(ahead);
      end

      if (cmd.decide) begin
        first_done_r <= first_done_r | first_hit;
        last_done_r  <= last_done_r | last_hit;
      end

      if (cmd.ins) begin
        cnt_r <= cnt_r + fct_pkg::CNT_ONE;
      end

      if (cmd.walk_init) begin
        gap_r <= 1'b0;
      end else if (walk_vld_r && ({1'b0, rd_start_r} > walk_r)) begin
        gap_r <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[src/fragment_coverage_tracker_top.sv]
// ----------------------------------------------------------------------------
// fragment_coverage_tracker_top: fragment reassembly coverage tracker
// Keeps a sorted table of received byte ranges and reports, per fragment,
// duplicate/stored/full status, first/last arrival, completeness and the
// running verification flag.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one beat per fragment (frag_offset, frag_length, verified).
//   out_ch : one result beat per fragment, in arrival order.
//   cfg_ch : writes total_length; always ready, write only while idle.
// Sequence: after accept the block scans every held chunk; a fragment to be
//   inserted then shifts the entries behind its insert position up one slot
//   and is written in place. The walk then reads every held chunk to check
//   that the ranges join up from zero to total_length, the result is loaded
//   and the block returns to idle. The run time is set by the single read
//   port of the chunk table: one entry per cycle for the scan, the shift and
//   the walk.
// Throughput: one fragment at a time; in_ch.ready is high only when idle.
// The result sits in an output register, so the next fragment is accepted
//   while it waits; a stalled receiver holds the block only when the
//   following result is ready to be loaded.
// Reset: clears the chunk count, arrival flags and total_length, and sets
//   the verified flag; table contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module fragment_coverage_tracker_top (
  input wire logic  clk,
  input wire logic  rst_n,
  fct_in_if.sink    in_ch,
  fct_out_if.source out_ch,
  fct_cfg_if.sink   cfg_ch
);

  fct_pkg::ctl_cmd_t cmd;
  fct_pkg::ctl_sts_t sts;
  fct_pkg::fct_res_t res;

  assign cfg_ch.ready = 1'b1;

  fct_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  fct_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_offset   (in_ch.frag_offset),
    .in_length   (in_ch.frag_length),
    .in_verified (in_ch.verified),
    .cfg_we      (cfg_ch.valid),
    .cfg_data    (cfg_ch.data),
    .res         (res)
  );

  assign out_ch.status         = res.status;
  assign out_ch.first_seen_now = res.first_seen_now;
  assign out_ch.last_seen_now  = res.last_seen_now;
  assign out_ch.complete       = res.complete;
  assign out_ch.all_verified   = res.all_verified;
  assign out_ch.chunks_held    = res.chunks_held;

endmodule

`default_nettype wire

[src/fct_checker.sv]
// ----------------------------------------------------------------------------
// fct_checker: fragment coverage tracker port checks
// Observes the top-level ports and flags illegal handshake and result sequences.
// ----------------------------------------------------------------------------
`default_nettype none

module fct_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_valid,
  input wire logic                       in_ready,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic [1:0]                 status,
  input wire logic                       first_seen_now,
  input wire logic                       last_seen_now,
  input wire logic [fct_pkg::HELD_W-1:0] chunks_held
);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("fragment accepted while previous one still in work");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(status) && $stable(chunks_held)))
    else $error("stalled result beat changed");

  a_no_arrival_unstored: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (status == fct_pkg::ST_DUP || status == fct_pkg::ST_FULL))
      |-> (!first_seen_now && !last_seen_now))
    else $error("arrival flag on unstored fragment");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && status == fct_pkg::ST_FULL)
      |-> (chunks_held == fct_pkg::HELD_W'(fct_pkg::MAX_CHUNKS)))
    else $error("table full reported below capacity");

endmodule

bind fragment_coverage_tracker_top fct_checker u_fct_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .status         (out_ch.status),
  .first_seen_now (out_ch.first_seen_now),
  .last_seen_now  (out_ch.last_seen_now),
  .chunks_held    (out_ch.chunks_held)
);

`default_nettype wire
